[src/saf_pkg.sv]
// ----------------------------------------------------------------------------
// saf_pkg
// Shared constants, codes and types of the slot allocator with free stack.
// ----------------------------------------------------------------------------
package saf_pkg;

    localparam int SLOTS     = 1024;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 1;

    // stream payload widths, padded to whole bytes
    localparam int IN_BITS  = MODE_W + IDX_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + IDX_W + 1 + 3 * CNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ADD      = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_REMOVE   = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_UNREMOVE = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_TRIM     = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_CLEAR    = MODE_W'(4);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REUSE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_TRIM = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } used_req_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } stack_req_t;

endpackage

[src/slot_allocator_free_stack_top.sv]
// ----------------------------------------------------------------------------
// slot_allocator_free_stack_top
// Slot allocator keeping holes: used-bit RAM, free-index stack RAM, storage
// high-water count and live count.
//
//   channel   dir   handshake            payload
//   s_        in    s_tvalid/s_tready    s_tdata: mode, slot_index
//   m_        out   m_tvalid/m_tready    m_tdata: ok .. free_count
//   cfg_      in    cfg_we               cfg_index, cfg_wdata
//
// Add, remove, unremove and unknown modes pass through the execute state
// before their result is loaded into the output register; an add that reuses
// a stack entry also passes through the pop state (second read of the
// used-bit RAM). Trim, when allowed, and clear walk the single read port of
// the used-bit RAM one slot a cycle. The next transaction is taken at the
// edge that loads the output register; a new one is accepted only in the idle
// state, so operations do not overlap. While the receiver holds a result, one
// more operation may finish, then the input stalls. Reset is synchronous; no
// clearing pass is needed since reads at or above the storage count are ignored.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [saf_pkg::IN_W-1:0]        s_tdata,   // mode, slot_index
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [saf_pkg::OUT_W-1:0]       m_tdata,   // ok, result_index, was_used,
                                                       // item_count, storage_count,
                                                       // free_count
    input  logic                            cfg_we,
    input  logic [saf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                            cfg_wdata
);
    import saf_pkg::*;

    used_req_t          used_req;
    stack_req_t         stack_req;
    logic               used_rdata;
    logic [IDX_W-1:0]   stack_rdata;

    saf_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .used_req    (used_req),
        .used_rdata  (used_rdata),
        .stack_req   (stack_req),
        .stack_rdata (stack_rdata)
    );

    saf_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_used_ram (
        .aclk  (aclk),
        .we    (used_req.we),
        .waddr (used_req.waddr),
        .wdata (used_req.wdata),
        .re    (used_req.re),
        .raddr (used_req.raddr),
        .rdata (used_rdata)
    );

    saf_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stack_req.we),
        .waddr (stack_req.waddr),
        .wdata (stack_req.wdata),
        .re    (stack_req.re),
        .raddr (stack_req.raddr),
        .rdata (stack_rdata)
    );

endmodule

[src/saf_ram.sv]
// ----------------------------------------------------------------------------
// saf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module saf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/saf_core.sv]
// ----------------------------------------------------------------------------
// saf_core
// Sequencer, counters and result register of the slot allocator; keeps the
// used bits and the free stack in two external RAMs.
// ----------------------------------------------------------------------------
module saf_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [saf_pkg::IN_W-1:0]        s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [saf_pkg::OUT_W-1:0]       m_tdata,
    input  logic                            cfg_we,
    input  logic [saf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                            cfg_wdata,
    output saf_pkg::used_req_t              used_req,
    input  logic                            used_rdata,
    output saf_pkg::stack_req_t             stack_req,
    input  logic [saf_pkg::IDX_W-1:0]       stack_rdata
);
    import saf_pkg::*;

    state_t             state_reg, state_next;
    logic               pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]   m_data_reg, m_data_next;
    logic [CNT_W-1:0]   depth_reg, depth_next;
    logic [CNT_W-1:0]   storage_reg, storage_next;
    logic [CNT_W-1:0]   live_reg, live_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   top_reg, top_next;
    logic [IDX_W-1:0]   walk_reg, walk_next;
    logic [IDX_W-1:0]   res_reg, res_next;
    logic               ok_reg, ok_next;
    logic               was_reg, was_next;
    logic               no_reuse_reg;
    logic               allow_trim_reg;

    logic [MODE_W-1:0]  in_mode;
    logic [IDX_W-1:0]   in_idx;
    logic               accept;
    logic               out_free;
    logic               idx_in_range;
    logic               top_in_range;
    logic               grow;
    logic               store_full;
    logic               stack_full;
    logic               walk_start;
    logic               walk_last;
    logic               walk_done;
    logic               finish;
    logic [CNT_W-1:0]   storage_m1;
    logic [CNT_W-1:0]   depth_m1;

    assign in_mode  = s_tdata[MODE_W-1:0];
    assign in_idx   = s_tdata[MODE_W +: IDX_W];
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && (!pend_reg || out_free);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign storage_m1   = storage_reg - CNT_W'(1);
    assign depth_m1     = depth_reg - CNT_W'(1);
    assign idx_in_range = {1'b0, idx_reg} < storage_reg;
    assign top_in_range = {1'b0, top_reg} < storage_reg;
    assign grow         = no_reuse_reg || (depth_reg == '0);
    assign store_full   = storage_reg == CNT_W'(SLOTS);
    assign stack_full   = depth_reg == CNT_W'(SLOTS);
    assign walk_last    = walk_reg == '0;

    always_comb begin
        walk_start = (state_reg == ST_EXEC) && (storage_reg != '0)
                     && (((mode_reg == MODE_TRIM) && allow_trim_reg)
                         || (mode_reg == MODE_CLEAR));
        // trim stops at the first used slot, clear visits every slot
        if (mode_reg == MODE_TRIM) begin
            walk_done = used_rdata || walk_last;
        end else begin
            walk_done = walk_last;
        end
        finish = ((state_reg == ST_EXEC) && !walk_start
                  && !((mode_reg == MODE_ADD) && !grow))
                 || (state_reg == ST_POP)
                 || ((state_reg == ST_WALK) && walk_done);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end else if (walk_start) begin
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                state_next = ST_IDLE;
            end
            ST_WALK: begin
                if (walk_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory requests
    always_comb begin
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        depth_next   = depth_reg;
        storage_next = storage_reg;
        live_next    = live_reg;
        mode_next    = mode_reg;
        idx_next     = idx_reg;
        top_next     = top_reg;
        walk_next    = walk_reg;
        res_next     = res_reg;
        ok_next      = ok_reg;
        was_next     = was_reg;
        used_req     = '0;
        stack_req    = '0;

        // result register, loaded only while idle so counts are final
        if ((state_reg == ST_IDLE) && pend_reg && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_W'({depth_reg, storage_reg, live_reg,
                                   was_reg, res_reg, ok_reg});
            pend_next    = 1'b0;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            mode_next       = in_mode;
            idx_next        = in_idx;
            res_next        = in_idx;
            ok_next         = (in_mode == MODE_CLEAR)
                              || ((in_mode == MODE_TRIM) && allow_trim_reg);
            used_req.re     = 1'b1;
            used_req.raddr  = in_idx;
            stack_req.re    = 1'b1;
            stack_req.raddr = depth_m1[IDX_W-1:0];
        end

        case (state_reg)
            ST_EXEC: begin
                was_next = used_rdata && idx_in_range;
                case (mode_reg)
                    MODE_ADD: begin
                        if (grow) begin
                            if (!store_full) begin
                                used_req.we    = 1'b1;
                                used_req.waddr = storage_reg[IDX_W-1:0];
                                used_req.wdata = 1'b1;
                                storage_next   = storage_reg + CNT_W'(1);
                                live_next      = live_reg + CNT_W'(1);
                                res_next       = storage_reg[IDX_W-1:0];
                                ok_next        = 1'b1;
                            end
                        end else begin
                            // pop now; a stale entry is dropped after the check
                            depth_next     = depth_m1;
                            top_next       = stack_rdata;
                            used_req.re    = 1'b1;
                            used_req.raddr = stack_rdata;
                        end
                    end
                    MODE_REMOVE: begin
                        if (used_rdata && idx_in_range && !stack_full) begin
                            stack_req.we    = 1'b1;
                            stack_req.waddr = depth_reg[IDX_W-1:0];
                            stack_req.wdata = idx_reg;
                            depth_next      = depth_reg + CNT_W'(1);
                            used_req.we     = 1'b1;
                            used_req.waddr  = idx_reg;
                            used_req.wdata  = 1'b0;
                            live_next       = live_reg - CNT_W'(1);
                            ok_next         = 1'b1;
                        end
                    end
                    MODE_UNREMOVE: begin
                        if (idx_in_range && !used_rdata) begin
                            used_req.we    = 1'b1;
                            used_req.waddr = idx_reg;
                            used_req.wdata = 1'b1;
                            live_next      = live_reg + CNT_W'(1);
                            ok_next        = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (walk_start) begin
                    walk_next      = storage_m1[IDX_W-1:0];
                    used_req.re    = 1'b1;
                    used_req.raddr = storage_m1[IDX_W-1:0];
                end
            end
            ST_POP: begin
                if (top_in_range && !used_rdata) begin
                    used_req.we    = 1'b1;
                    used_req.waddr = top_reg;
                    used_req.wdata = 1'b1;
                    live_next      = live_reg + CNT_W'(1);
                    res_next       = top_reg;
                    ok_next        = 1'b1;
                end
            end
            ST_WALK: begin
                // in clear, the read of the next lower slot overlaps the write of this one
                if (mode_reg == MODE_TRIM) begin
                    if (!used_rdata) begin
                        storage_next = storage_m1;
                        walk_next    = walk_reg - IDX_W'(1);
                        if (!walk_last) begin
                            used_req.re    = 1'b1;
                            used_req.raddr = walk_reg - IDX_W'(1);
                        end
                    end
                end else begin
                    if (used_rdata) begin
                        if (!stack_full) begin
                            stack_req.we    = 1'b1;
                            stack_req.waddr = depth_reg[IDX_W-1:0];
                            stack_req.wdata = walk_reg;
                            depth_next      = depth_reg + CNT_W'(1);
                            used_req.we     = 1'b1;
                            used_req.waddr  = walk_reg;
                            used_req.wdata  = 1'b0;
                            live_next       = live_reg - CNT_W'(1);
                        end else begin
                            ok_next = 1'b0;
                        end
                    end
                    if (!walk_last) begin
                        walk_next      = walk_reg - IDX_W'(1);
                        used_req.re    = 1'b1;
                        used_req.raddr = walk_reg - IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        if (finish) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            depth_reg   <= '0;
            storage_reg <= '0;
            live_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            depth_reg   <= depth_next;
            storage_reg <= storage_next;
            live_reg    <= live_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        mode_reg   <= mode_next;
        idx_reg    <= idx_next;
        top_reg    <= top_next;
        walk_reg   <= walk_next;
        res_reg    <= res_next;
        ok_reg     <= ok_next;
        was_reg    <= was_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            no_reuse_reg   <= 1'b0;
            allow_trim_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NO_REUSE:   no_reuse_reg   <= cfg_wdata;
                CFG_ALLOW_TRIM: allow_trim_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    a_live_within_storage: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= storage_reg)
        else $error("live count exceeds storage count");

    a_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (storage_reg <= CNT_W'(SLOTS)) && (depth_reg <= CNT_W'(SLOTS)))
        else $error("storage or stack count beyond slot count");

    a_accept_starts_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted transaction did not start execution");

    a_finish_sets_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg != ST_IDLE) && (state_next == ST_IDLE)) |=> pend_reg)
        else $error("finished operation left no pending result");

    a_result_from_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(pend_reg))
        else $error("result presented without a pending operation");

endmodule
